// ===== design/assert_macros.svh =====
// Assertion macros used by the console top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, active during reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

// ===== design/tcw_pkg.sv =====
// Types and constants of the text console character writer.
package tcw_pkg;

   // Operation selector codes on req_func.
   localparam logic [1:0] FUNC_PUT  = 2'd0;
   localparam logic [1:0] FUNC_READ = 2'd1;
   localparam logic [1:0] FUNC_FILL = 2'd2;

   // Control characters.
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
   localparam logic [15:0] BLANK_CELL       = 16'h0720;

   // Command queue between front and back; depth must be a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_BACKSPACE,
      OP_NEWLINE,
      OP_RETURN,
      OP_READ,
      OP_FILL,
      OP_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_code;
      logic [7:0]  fill_attr;
      logic [10:0] cell_index;
      logic        in_range;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_COPY,
      ST_BLANK
   } back_state_type;

endpackage

// ===== design/tcw_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcw_front.sv =====
// Front end: accepts request transactions and decodes them into commands.
module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_char_code,
   input  logic [10:0]      req_cell_index,
   input  logic [3:0]       req_fill_foreground,
   input  logic [3:0]       req_fill_background,
   input  logic             q_full,
   output logic             q_push,
   output tcw_pkg::cmd_type q_cmd
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd            = '0;
      q_cmd.char_code  = req_char_code;
      q_cmd.fill_attr  = {req_fill_background, req_fill_foreground};
      q_cmd.cell_index = req_cell_index;
      q_cmd.in_range   = 32'(req_cell_index) < CELLS;
      unique case (req_func)
         FUNC_PUT: begin
            priority if (req_char_code == CH_BACKSPACE) begin
               q_cmd.kind = OP_BACKSPACE;
            end else if (req_char_code == CH_NEWLINE) begin
               q_cmd.kind = OP_NEWLINE;
            end else if (req_char_code == CH_RETURN) begin
               q_cmd.kind = OP_RETURN;
            end else begin
               q_cmd.kind = OP_PRINT;
            end
         end
         FUNC_READ: q_cmd.kind = OP_READ;
         FUNC_FILL: q_cmd.kind = OP_FILL;
         default:   q_cmd.kind = OP_NONE;
      endcase
   end

endmodule

// ===== design/tcw_queue.sv =====
// Short command FIFO between the front end and the execution back end.
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             q_valid,
   output logic             q_full,
   output tcw_pkg::cmd_type q_cmd
);
   import tcw_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == QCNT_W'(QDEPTH);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/tcw_back.sv =====
// Back end: executes commands on the cursor and the screen RAM, holds the result.
module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  tcw_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic [7:0]       text_color,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [10:0]      rsp_cursor_pos,
   output logic [15:0]      rsp_read_data
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int POS_W  = $clog2(CELLS + COLUMNS + 1);
   localparam int ROW_W  = $clog2(ROWS + 2);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST_ROW = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ADDR_COLS     = ADDR_W'(COLUMNS);
   localparam logic [POS_W-1:0]  POS_LAST_ROW  = POS_W'(CELLS - COLUMNS);
   localparam logic [POS_W-1:0]  POS_COLS      = POS_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LIMIT     = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       fill_word_ff, fill_word_in;
   logic              pend_print_ff, pend_print_in;
   logic [7:0]        pend_char_ff, pend_char_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [15:0]       rsp_data_ff;

   logic              rsp_load;
   logic [POS_W-1:0]  rsp_pos_new;
   logic [15:0]       rsp_data_new;
   logic              slot_free;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;
   logic [ADDR_W+10:0] idx_ext;
   logic [POS_W+10:0]  pos_ext;
   logic [POS_W-1:0]  pos_dec;
   logic [POS_W-1:0]  pos_inc;
   logic [POS_W-1:0]  pos_nl;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_ext   = {ADDR_W'(0), q_cmd.cell_index};
   assign pos_dec   = pos_ff - POS_W'(1);
   assign pos_inc   = pos_ff + POS_W'(1);
   assign pos_nl    = pos_ff - POS_W'(col_ff) + POS_COLS;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pos_in        = pos_ff;
      fill_word_in  = fill_word_ff;
      pend_print_in = pend_print_ff;
      pend_char_in  = pend_char_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = {text_color, CH_SPACE};
      rd_addr       = '0;
      rsp_load      = 1'b0;
      rsp_pos_new   = pos_ff;
      rsp_data_new  = '0;

      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = (state_ff == ST_INIT) ? BLANK_CELL : fill_word_ff;
            if (cnt_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
               rsp_load = state_ff == ST_FILL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            rd_addr = idx_ext[ADDR_W-1:0];
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  OP_PRINT: begin
                     if (row_ff >= ROW_LIMIT) begin
                        state_in      = ST_COPY;
                        cnt_in        = '0;
                        pend_print_in = 1'b1;
                        pend_char_in  = q_cmd.char_code;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ff[ADDR_W-1:0];
                        wr_data = {text_color, q_cmd.char_code};
                        if (col_ff == COL_LAST) begin
                           col_in = '0;
                           row_in = row_ff + ROW_W'(1);
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                        pos_in      = pos_inc;
                        rsp_load    = 1'b1;
                        rsp_pos_new = pos_inc;
                     end
                  end
                  OP_BACKSPACE: begin
                     wr_en    = 1'b1;
                     rsp_load = 1'b1;
                     if (pos_ff == '0) begin
                        wr_addr = '0;
                     end else begin
                        wr_addr     = pos_dec[ADDR_W-1:0];
                        pos_in      = pos_dec;
                        rsp_pos_new = pos_dec;
                        if (col_ff == '0) begin
                           col_in = COL_LAST;
                           row_in = row_ff - ROW_W'(1);
                        end else begin
                           col_in = col_ff - COL_W'(1);
                        end
                     end
                  end
                  OP_NEWLINE: begin
                     if (row_ff >= ROW_LAST) begin
                        state_in      = ST_COPY;
                        cnt_in        = '0;
                        pend_print_in = 1'b0;
                     end else begin
                        row_in      = row_ff + ROW_W'(1);
                        col_in      = '0;
                        pos_in      = pos_nl;
                        rsp_load    = 1'b1;
                        rsp_pos_new = pos_nl;
                     end
                  end
                  OP_RETURN: begin
                     if (row_ff >= ROW_LIMIT) begin
                        state_in      = ST_COPY;
                        cnt_in        = '0;
                        pend_print_in = 1'b0;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (q_cmd.in_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_FILL: begin
                     state_in     = ST_FILL;
                     cnt_in       = '0;
                     fill_word_in = {q_cmd.fill_attr, q_cmd.char_code};
                     row_in       = '0;
                     col_in       = '0;
                     pos_in       = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_load     = 1'b1;
            rsp_data_new = rd_data;
            state_in     = ST_IDLE;
         end

         // Row shift: read one row ahead, write back in the following cycle.
         ST_COPY: begin
            if (cnt_ff != ADDR_LAST_ROW) begin
               rd_addr = cnt_ff + ADDR_COLS;
            end
            if (cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff - ADDR_W'(1);
               wr_data = rd_data;
            end
            if (cnt_ff == ADDR_LAST_ROW) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end

         // Blank the last row; a deferred printable lands in its first cell.
         ST_BLANK: begin
            wr_en = 1'b1;
            if (cnt_ff == ADDR_LAST_ROW && pend_print_ff) begin
               wr_data = {text_color, pend_char_ff};
            end
            if (cnt_ff == ADDR_LAST) begin
               state_in    = ST_IDLE;
               row_in      = ROW_LAST;
               col_in      = COL_W'(pend_print_ff);
               pos_in      = POS_LAST_ROW + POS_W'(pend_print_ff);
               rsp_load    = 1'b1;
               rsp_pos_new = POS_LAST_ROW + POS_W'(pend_print_ff);
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pos_ff        <= '0;
         pend_print_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pos_ff        <= pos_in;
         pend_print_ff <= pend_print_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_word_ff <= fill_word_in;
      pend_char_ff <= pend_char_in;
      if (rsp_load) begin
         rsp_pos_ff  <= rsp_pos_new;
         rsp_data_ff <= rsp_data_new;
      end
   end

   assign pos_ext        = {11'd0, rsp_pos_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = pos_ext[10:0];
   assign rsp_read_data  = rsp_data_ff;

endmodule

// ===== design/text_console_char_writer.sv =====
// Top level of the text console character writer.
//
// Usage: request transactions (req_*) carry one operation each: put character,
// read cell or fill screen. Every request gives exactly one response transaction
// (rsp_*) with the linear cursor position and, for reads, the cell word.
// csr_write_en/csr_write_data load the attribute used for written characters;
// write it only while no request is outstanding.
// Execution, with an idle back end: a put character that does not scroll,
// func 3 or an out-of-range read leaves the queue and loads the response
// register in the same cycle, so such requests run back to back at one item
// per cycle while rsp_stall is low. An in-range read also passes through the
// registered RAM read. A scroll copies ROWS*COLUMNS-COLUMNS words, then
// blanks COLUMNS cells. A fill writes one cell per cycle. The single RAM
// write port sets the pace of scrolls and fills.
// Reset: synchronous; afterwards the screen is cleared to grey blanks in a pass
// over all ROWS*COLUMNS cells (2000 by default). Requests are queued meanwhile,
// up to the queue depth, and executed once the pass ends.
// Backpressure: the result sits in an output register; while rsp_stall is high
// the back end holds it, the queue fills, and then req_stall rises.
module text_console_char_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   input  logic [3:0]  req_fill_foreground,
   input  logic [3:0]  req_fill_background,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_pos,
   output logic [15:0] rsp_read_data,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);
   import tcw_pkg::*;

`include "assert_macros.svh"

   localparam int CELLS = ROWS * COLUMNS;

   logic [7:0] text_color_ff, text_color_in;
   logic       q_push;
   logic       q_pop;
   logic       q_valid;
   logic       q_full;
   cmd_type    push_cmd;
   cmd_type    head_cmd;

   // Attribute register; reset value is light grey on black.
   assign text_color_in = csr_write_en ? csr_write_data : text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   // Decode requests into commands.
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .req_fill_foreground (req_fill_foreground),
      .req_fill_background (req_fill_background),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (push_cmd)
   );

   // Decouples intake from long scroll and fill sweeps.
   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .q_cmd    (head_cmd)
   );

   // Cursor, screen RAM and response register.
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (head_cmd),
      .q_pop          (q_pop),
      .text_color     (text_color_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_read_data  (rsp_read_data)
   );

   // Back end only takes a command that is really there.
   `ASSERT_IMPLIES(a_pop_not_empty, clock, reset, q_pop, q_valid)
   // A command is taken only when the response register can accept its result.
   `ASSERT_IMPLIES(a_pop_slot_free, clock, reset, q_pop, !rsp_valid || !rsp_stall)
   // Reported cursor never exceeds ROWS*COLUMNS, one past the last cell of the screen.
   `ASSERT_IMPLIES(a_pos_range, clock, reset, rsp_valid, 32'(rsp_cursor_pos) <= CELLS)
   // Reset leaves no response and no queued command behind.
   `ASSERT_NEXT(a_reset_clean, clock, reset, !rsp_valid && !q_valid)

endmodule

// ===== tb/sv/tb_text_console_char_writer.sv =====
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps

module tb_text_console_char_writer;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   // func 3 is not decoded by the block; it must act as a no-op
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // Worst case is a scroll or fill per transaction plus stalls, taken a few times over
   localparam int CYCLE_LIMIT = 8_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_PUT;
   logic [7:0]  req_char_code = '0;
   logic [10:0] req_cell_index = '0;
   logic [3:0]  req_fill_foreground = '0;
   logic [3:0]  req_fill_background = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [10:0] rsp_cursor_pos;
   logic [15:0] rsp_read_data;
   logic        csr_write_en = 1'b0;
   logic [7:0]  csr_write_data = '0;

   typedef struct {
      logic [10:0] cursor_pos;
      logic [15:0] read_data;
   } console_result_type;

   // Expected responses, oldest first
   console_result_type pending_results[$];

   // Shadow copy of the console state
   logic [15:0] shadow_cells [CELLS];
   logic [7:0]  shadow_color;
   int          shadow_row;
   int          shadow_col;

   // Run control shared by the stimulus and the response side
   bit quiet_mode     = 1'b0;  // no idling on either side while set
   int receiver_hold  = 0;     // cycles the response side still holds off
   int failures       = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   int reads_done     = 0;
   int fills_done     = 0;
   int scrolls_done   = 0;
   int color_writes   = 0;

   text_console_char_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .req_fill_foreground(req_fill_foreground),
      .req_fill_background(req_fill_background),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_read_data      (rsp_read_data),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   always #2 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Console predictor
   // ---------------------------------------------------------------------

   // Put character: control codes, write at cursor, wrap, deferred scroll.
   task automatic console_put(input logic [7:0] ch);
      int i;
      if (ch == CH_BACKSPACE) begin
         // At home the cursor stays but the home cell is still blanked
         if (shadow_col > 0) begin
            shadow_col--;
         end else if (shadow_row > 0) begin
            shadow_col = COLUMNS - 1;
            shadow_row--;
         end
         shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, CH_SPACE};
         return;
      end
      if (ch == CH_NEWLINE) begin
         shadow_col = 0;
         shadow_row++;
      end
      // Row at or past the bottom (wrap off last row or newline there): scroll up
      if (shadow_row >= ROWS) begin
         for (i = 0; i < CELLS - COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
         for (i = CELLS - COLUMNS; i < CELLS; i++)
            shadow_cells[i] = {shadow_color, CH_SPACE};
         shadow_row = ROWS - 1;
         shadow_col = 0;
         scrolls_done++;
      end
      if (ch != CH_NEWLINE && ch != CH_RETURN) begin
         shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
         shadow_col++;
         // Wrap leaves the row at ROWS on the last line; scroll waits for next put
         if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
         end
      end
   endtask

   // Apply one accepted transaction to the shadow state and queue its response.
   task automatic predict_item(input logic [1:0] func, input logic [7:0] ch,
                               input logic [10:0] idx, input logic [3:0] fg,
                               input logic [3:0] bg);
      console_result_type res;
      int i;
      res.read_data = '0;
      case (func)
         FUNC_PUT: begin
            console_put(ch);
         end
         FUNC_READ: begin
            reads_done++;
            if (idx < CELLS)
               res.read_data = shadow_cells[idx];
         end
         FUNC_FILL: begin
            fills_done++;
            for (i = 0; i < CELLS; i++)
               shadow_cells[i] = {bg, fg, ch};
            shadow_row = 0;
            shadow_col = 0;
         end
         default: begin
         end
      endcase
      res.cursor_pos = 11'(shadow_row * COLUMNS + shadow_col);
      pending_results.push_back(res);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one transaction; returns at the edge where it is accepted.
   task automatic send_item(input logic [1:0] func, input logic [7:0] ch,
                            input logic [10:0] idx, input logic [3:0] fg,
                            input logic [3:0] bg);
      int gap;
      gap = 0;
      if (!quiet_mode && $urandom_range(99) < 24)
         gap = $urandom_range(2, 1);
      // valid is only lowered when a gap is taken, so back-to-back stays high
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= func;
      req_char_code       <= ch;
      req_cell_index      <= idx;
      req_fill_foreground <= fg;
      req_fill_background <= bg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(func, ch, idx, fg, bg);
      items_sent++;
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_item(FUNC_PUT, ch, 11'($urandom_range(2047)), 4'($urandom_range(15)),
                4'($urandom_range(15)));
   endtask

   task automatic read_cell(input logic [10:0] idx);
      send_item(FUNC_READ, 8'($urandom_range(255)), idx, 4'($urandom_range(15)),
                4'($urandom_range(15)));
   endtask

   task automatic fill_screen(input logic [7:0] ch, input logic [3:0] fg,
                              input logic [3:0] bg);
      send_item(FUNC_FILL, ch, 11'($urandom_range(2047)), fg, bg);
   endtask

   function automatic logic [7:0] printable_char();
      return 8'($urandom_range(126, 32));
   endfunction

   // Read somewhere at or just behind the cursor, where recent writes landed.
   function automatic logic [10:0] cell_near_cursor();
      int pos;
      pos = shadow_row * COLUMNS + shadow_col - $urandom_range(120);
      if (pos < 0) pos = 0;
      if (pos > CELLS - 1) pos = CELLS - 1;
      return 11'(pos);
   endfunction

   // Stop offering and wait until every queued response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Only called with nothing outstanding.
   task automatic write_text_color(input logic [7:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow_color = value;
      color_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset contents, control characters, no-op selector and fill extremes.
   task automatic test_controls();
      read_cell(11'd0);
      read_cell(11'(CELLS - 1));
      read_cell(11'(CELLS));          // out of range reads give zero
      read_cell(11'h7FF);
      put_char(CH_BACKSPACE);         // backspace at home blanks cell 0, cursor stays
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CH_RETURN);            // return without scroll: cursor unchanged
      put_char(CH_NEWLINE);
      put_char(CH_BACKSPACE);         // column zero: back to end of row above
      read_cell(11'(COLUMNS - 1));
      read_cell(11'd1);
      read_cell(11'd2);
      send_item(FUNC_UNUSED, 8'hFF, 11'h7FF, 4'hF, 4'hF);
      send_item(FUNC_UNUSED, 8'h00, 11'h000, 4'h0, 4'h0);
      fill_screen(8'hFF, 4'hF, 4'hF);
      read_cell(11'd1234);
      fill_screen(8'h00, 4'h0, 4'h0);
      read_cell(11'(CELLS - 1));
      wait_for_results();
   endtask

   // Attribute register at its extremes and a few patterns in between.
   task automatic test_text_colors();
      logic [7:0] colors [5];
      int i;
      colors = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'($urandom_range(255))};
      for (i = 0; i < 5; i++) begin
         write_text_color(colors[i]);
         put_char(printable_char());
         put_char(printable_char());
         put_char(CH_BACKSPACE);
         read_cell(cell_near_cursor());
         wait_for_results();
      end
   endtask

   // Walk to the bottom row and exercise wrap off the end, deferred scroll,
   // backspace from the off-screen row, and return/newline triggered scrolls.
   task automatic test_bottom_edge();
      fill_screen(8'($urandom_range(255)), 4'($urandom_range(15)),
                  4'($urandom_range(15)));
      repeat (ROWS - 1) put_char(CH_NEWLINE);
      repeat (COLUMNS) put_char(printable_char());      // cursor now ROWS*COLUMNS
      read_cell(11'(CELLS - 1));
      put_char(CH_BACKSPACE);                          // back onto the last cell
      put_char(printable_char());                      // wrap off again
      put_char(CH_RETURN);                             // return at row ROWS scrolls
      read_cell(11'(CELLS - COLUMNS - 1));
      repeat (COLUMNS) put_char(printable_char());
      put_char(printable_char());                      // deferred scroll, then write
      read_cell(11'(CELLS - COLUMNS));
      read_cell(11'(CELLS - COLUMNS - 1));
      repeat (COLUMNS - 1) put_char(printable_char());
      put_char(CH_NEWLINE);                            // row goes past ROWS
      put_char(CH_NEWLINE);                            // newline on last row
      read_cell(11'(CELLS - 1));
      read_cell(11'(CELLS - COLUMNS - 2));
      wait_for_results();
   endtask

   // Receiver holds off long enough for the queue to fill and stall the input.
   task automatic test_backpressure();
      int i;
      receiver_hold = 300;
      for (i = 0; i < 16; i++) begin
         if (i % 4 == 3)
            read_cell(cell_near_cursor());
         else
            put_char(printable_char());
      end
      wait_for_results();
   endtask

   // Mostly text with sparse control codes, plus reads, noise and rare fills.
   task automatic test_random_traffic();
      int phase;
      int n;
      int pick;
      int sub;
      for (phase = 0; phase < 6; phase++) begin
         write_text_color(8'($urandom_range(255)));
         quiet_mode = (phase == 2);
         for (n = 0; n < 80; n++) begin
            pick = $urandom_range(999);
            if (pick < 620) begin
               sub = $urandom_range(99);
               if (sub < 8)
                  put_char(CH_NEWLINE);
               else if (sub < 11)
                  put_char(CH_RETURN);
               else if (sub < 15)
                  put_char(CH_BACKSPACE);
               else if (sub < 20)
                  put_char(8'($urandom_range(255)));
               else
                  put_char(printable_char());
            end else if (pick < 900) begin
               if ($urandom_range(99) < 80)
                  read_cell(cell_near_cursor());
               else
                  read_cell(11'($urandom_range(2047)));
            end else if (pick < 930) begin
               send_item(FUNC_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                         4'($urandom_range(15)), 4'($urandom_range(15)));
            end else if (pick < 938) begin
               fill_screen(8'($urandom_range(255)), 4'($urandom_range(15)),
                           4'($urandom_range(15)));
            end else begin
               put_char(8'($urandom_range(255)));
            end
         end
         wait_for_results();
         quiet_mode = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: checks each accepted transaction and drives rsp_stall
   // ---------------------------------------------------------------------
   initial begin : response_checker
      console_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding: cursor_pos %0d read_data %h",
                      rsp_cursor_pos, rsp_read_data);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, got %0d", want.cursor_pos,
                         rsp_cursor_pos);
                  failures++;
               end
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  failures++;
               end
            end
         end
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (receiver_hold > 0) begin
            rsp_stall <= 1'b1;
            receiver_hold--;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(99) < 24);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int k;
      for (k = 0; k < CELLS; k++)
         shadow_cells[k] = BLANK_CELL;
      shadow_color = TEXT_COLOR_RESET;
      shadow_row   = 0;
      shadow_col   = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Requests sent here queue up behind the post-reset clearing pass
      test_controls();
      test_text_colors();
      test_bottom_edge();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      // Catch any stray response after the last expected one
      repeat (100) @(posedge clock);

      $display("Covered %0d transactions (%0d reads, %0d fills, %0d scrolls), %0d color writes",
               items_sent, reads_done, fills_done, scrolls_done, color_writes);
      $display("Included a long response hold-off with input stall and idle-free stretches");
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
